// ===== src/adsr_pkg.sv =====
package adsr_pkg;

    localparam int TIME_BITS     = 24;
    localparam int LEVEL_BITS    = 16;
    localparam int FRAC_BITS     = 16;
    localparam int GAIN_BITS     = FRAC_BITS + 1;
    localparam int CURVE_ENTRIES = 1024;
    localparam int CURVE_BITS    = $clog2(CURVE_ENTRIES);
    localparam int IDX_BITS      = CURVE_BITS + 1;
    localparam int DIV_CNT_BITS  = $clog2(FRAC_BITS);
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL     = '1;
    localparam logic [LEVEL_BITS-1:0] SUSTAIN_RESET  = '1;
    localparam logic [FRAC_BITS-1:0]  FRAC_MAX       = '1;
    localparam logic [GAIN_BITS-1:0]  GAIN_ONE       = GAIN_BITS'(1) << FRAC_BITS;

    localparam longint unsigned Q30_ONE       = 64'd1073741824;
    localparam longint unsigned E_MINUS_1_Q30 = 64'd1844991065;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_ATTACK_LEN    = 3'd0;
    localparam logic [2:0] REG_DECAY_LEN     = 3'd1;
    localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd2;
    localparam logic [2:0] REG_RELEASE_LEN   = 3'd3;
    localparam logic [2:0] REG_PEAK_LEVEL    = 3'd4;

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_ENDED   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_CURVE,
        BK_INTERP,
        BK_MUL,
        BK_FIN
    } back_state_t;

    typedef struct packed {
        logic [1:0] trigger;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  playing;
        logic [2:0]            stage;
    } out_item_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  attack_len;
        logic [TIME_BITS-1:0]  decay_len;
        logic [LEVEL_BITS-1:0] sustain_level;
        logic [TIME_BITS-1:0]  release_len;
        logic [LEVEL_BITS-1:0] peak_level;
    } cfg_t;

    typedef logic [CURVE_ENTRIES:0][GAIN_BITS-1:0] curve_tab_t;

    // Restoring division by shift and subtract, used only while the curve
    // table is built at elaboration.
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rest;
        quo  = 0;
        rest = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rest = (rest << 1) | ((num >> b) & 64'd1);
            quo  = quo << 1;
            if (rest >= den)
            begin
                rest = rest - den;
                quo  = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // ln(1 + (e-1)u) sampled at CURVE_ENTRIES+1 points, Q.16, built at elaboration
    // from an atanh series in Q30.
    function automatic curve_tab_t build_curve();
        curve_tab_t      tab;
        longint unsigned y;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        longint unsigned prev;
        prev = 0;
        for (int k = 0; k <= CURVE_ENTRIES; k++)
        begin
            y    = Q30_ONE + ((E_MINUS_1_Q30 * longint'(k)) >> CURVE_BITS);
            z    = udiv64((y - Q30_ONE) << 30, y + Q30_ONE);
            z2   = (z * z) >> 30;
            term = z;
            sum  = 0;
            for (int n = 0; n < 24; n++)
            begin
                sum  = sum + udiv64(term, longint'(2 * n + 1));
                term = (term * z2) >> 30;
            end
            v = (2 * sum + 64'd8192) >> 14;
            if (v > 64'd65536)
            begin
                v = 64'd65536;
            end
            if (v < prev)
            begin
                v = prev;
            end
            tab[k] = v[GAIN_BITS-1:0];
            prev   = v;
        end
        return tab;
    endfunction

    localparam curve_tab_t CURVE_TAB = build_curve();

endpackage

// ===== src/adsr_front.sv =====
module adsr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  adsr_pkg::in_item_t item,
    output logic              q_valid,
    output adsr_pkg::in_item_t q_item,
    input  logic              q_pop
);
    import adsr_pkg::*;

    // Two-entry queue between the port and the sequencer.
    in_item_t   slot_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign item_stall = (count_reg == 2'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != 2'd0);
    assign pop        = q_pop && q_valid;
    assign q_item     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== src/adsr_back.sv =====
module adsr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  adsr_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  adsr_pkg::in_item_t  q_item,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output adsr_pkg::out_item_t result
);
    import adsr_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    phase_t                  phase_reg;
    logic [TIME_BITS-1:0]    pos_reg;

    // Item in flight.
    phase_t                  work_ph_reg;
    phase_t                  res_ph_reg;
    logic [TIME_BITS-1:0]    res_pos_reg;
    logic                    res_alive_reg;
    logic [LEVEL_BITS-1:0]   res_level_reg;
    logic [TIME_BITS-1:0]    len_reg;
    logic [TIME_BITS-1:0]    rem_reg;
    logic [FRAC_BITS-1:0]    q_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [GAIN_BITS-1:0]    lo_reg;
    logic [GAIN_BITS-1:0]    hi_reg;
    logic [FRAC_BITS-1:0]    frac_reg;
    logic [GAIN_BITS-1:0]    gain_reg;

    logic                    out_valid_reg;
    out_item_t               out_reg;

    // Entry decode.
    logic                    held;
    phase_t                  ph0;
    logic [TIME_BITS-1:0]    pos0;
    logic [TIME_BITS-1:0]    pos1;
    phase_t                  e_ph;
    logic [TIME_BITS-1:0]    e_pos;
    logic                    e_alive;
    logic [LEVEL_BITS-1:0]   e_level;
    logic [TIME_BITS-1:0]    e_len;
    logic                    e_need_div;
    logic                    e_sat;
    logic                    e_direct;

    logic [LEVEL_BITS-1:0]   pk;
    logic [LEVEL_BITS-1:0]   s;

    logic [TIME_BITS:0]      r2;
    logic                    ge;

    logic [GAIN_BITS-1:0]    u;
    logic                    u_sat;
    logic [IDX_BITS-1:0]     idx;

    logic [2*GAIN_BITS-2:0]  interp_prod;
    logic [GAIN_BITS-1:0]    interp_g;

    logic [GAIN_BITS-1:0]    mul_a;
    logic [LEVEL_BITS-1:0]   mul_b;
    logic [GAIN_BITS+LEVEL_BITS-1:0] mul_p;
    logic [LEVEL_BITS-1:0]   mul_hi;
    logic [LEVEL_BITS-1:0]   mul_level;

    logic                    slot_free;
    logic                    commit;

    assign pk = (cfg.peak_level == '0) ? LEVEL_FULL : cfg.peak_level;
    assign s  = cfg.sustain_level;

    always_comb
    begin
        held  = (q_item.trigger != 2'd0);
        ph0   = phase_reg;
        pos0  = pos_reg;
        if (q_item.restart)
        begin
            pos0 = '0;
            ph0  = (cfg.attack_len == '0) ? PH_DECAY : PH_ATTACK;
        end
        if (ph0 == PH_ATTACK && cfg.attack_len == '0)
        begin
            ph0  = PH_DECAY;
            pos0 = '0;
        end
        if (ph0 == PH_DECAY && cfg.decay_len == '0)
        begin
            ph0  = PH_SUSTAIN;
            pos0 = '0;
        end
        pos1       = pos0 + TIME_BITS'(1);
        e_ph       = ph0;
        e_pos      = pos0;
        e_alive    = 1'b0;
        e_level    = '0;
        e_len      = cfg.attack_len;
        e_need_div = 1'b0;
        e_direct   = 1'b1;
        case (ph0)
            PH_ATTACK:
            begin
                e_len      = cfg.attack_len;
                e_alive    = 1'b1;
                e_need_div = 1'b1;
                e_direct   = 1'b0;
                if (pos1 >= cfg.attack_len)
                begin
                    e_ph  = PH_DECAY;
                    e_pos = '0;
                end
                else
                begin
                    e_pos = pos1;
                end
            end
            PH_DECAY:
            begin
                e_len      = cfg.decay_len;
                e_alive    = 1'b1;
                e_need_div = 1'b1;
                e_direct   = 1'b0;
                if (pos1 >= cfg.decay_len)
                begin
                    e_ph  = PH_SUSTAIN;
                    e_pos = '0;
                end
                else
                begin
                    e_pos = pos1;
                end
            end
            PH_SUSTAIN:
            begin
                if (s == '0)
                begin
                    e_ph = PH_ENDED;
                end
                else
                begin
                    e_level = s;
                    e_alive = 1'b1;
                    e_ph    = held ? PH_SUSTAIN : PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                e_len = cfg.release_len;
                if (cfg.release_len == '0 || pos0 >= cfg.release_len)
                begin
                    e_ph = PH_ENDED;
                end
                else
                begin
                    e_alive    = 1'b1;
                    e_need_div = 1'b1;
                    e_direct   = 1'b0;
                    e_pos      = pos1;
                end
                if (held)
                begin
                    e_pos = '0;
                    e_ph  = PH_ATTACK;
                end
            end
            default:
            begin
                e_ph = PH_ENDED;
                if (held)
                begin
                    e_pos = '0;
                    e_ph  = PH_ATTACK;
                end
            end
        endcase
        e_sat = e_need_div && (pos0 >= e_len);
    end

    // One restoring divide step per cycle.
    assign r2 = {1'b0, rem_reg} << 1;
    assign ge = (r2 >= {1'b0, len_reg});

    // Curve lookup address.
    always_comb
    begin
        if (work_ph_reg == PH_DECAY)
        begin
            u = GAIN_ONE - {1'b0, q_reg};
        end
        else
        begin
            u = {1'b0, q_reg};
        end
        u_sat = u[FRAC_BITS];
        idx   = IDX_BITS'(u >> (FRAC_BITS - CURVE_BITS));
    end

    assign interp_prod = (hi_reg - lo_reg) * frac_reg;
    assign interp_g    = lo_reg + GAIN_BITS'(interp_prod >> FRAC_BITS);

    always_comb
    begin
        mul_a = gain_reg;
        mul_b = s;
        case (work_ph_reg)
            PH_ATTACK:
            begin
                mul_a = {1'b0, q_reg};
                mul_b = pk;
            end
            PH_DECAY:
            begin
                mul_a = gain_reg;
                mul_b = (pk >= s) ? (pk - s) : (s - pk);
            end
            default:
            begin
                mul_a = gain_reg;
                mul_b = s;
            end
        endcase
        mul_p  = mul_a * mul_b;
        mul_hi = LEVEL_BITS'(mul_p >> FRAC_BITS);
        if (work_ph_reg == PH_DECAY)
        begin
            mul_level = (pk >= s) ? (s + mul_hi) : (s - mul_hi);
        end
        else
        begin
            mul_level = mul_hi;
        end
    end

    assign slot_free = !out_valid_reg || !result_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (e_direct)
                    begin
                        state_next = BK_FIN;
                    end
                    else if (e_sat)
                    begin
                        state_next = (ph0 == PH_ATTACK) ? BK_MUL : BK_CURVE;
                    end
                    else
                    begin
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = (work_ph_reg == PH_ATTACK) ? BK_MUL : BK_CURVE;
                end
            end
            BK_CURVE:  state_next = BK_INTERP;
            BK_INTERP: state_next = BK_MUL;
            BK_MUL:    state_next = BK_FIN;
            BK_FIN:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        q_pop  = (state_reg == BK_IDLE) && q_valid;
        commit = (state_reg == BK_FIN) && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            phase_reg     <= PH_ATTACK;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                phase_reg     <= res_ph_reg;
                pos_reg       <= res_pos_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                work_ph_reg   <= ph0;
                res_ph_reg    <= e_ph;
                res_pos_reg   <= e_pos;
                res_alive_reg <= e_alive;
                res_level_reg <= e_level;
                len_reg       <= e_len;
                rem_reg       <= pos0;
                q_reg         <= e_sat ? FRAC_MAX : '0;
                cnt_reg       <= DIV_CNT_BITS'(FRAC_BITS - 1);
            end
            BK_DIV:
            begin
                rem_reg <= ge ? TIME_BITS'(r2 - {1'b0, len_reg}) : TIME_BITS'(r2);
                q_reg   <= {q_reg[FRAC_BITS-2:0], ge};
                cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
            end
            BK_CURVE:
            begin
                if (u_sat)
                begin
                    lo_reg   <= CURVE_TAB[CURVE_ENTRIES];
                    hi_reg   <= CURVE_TAB[CURVE_ENTRIES];
                    frac_reg <= '0;
                end
                else
                begin
                    lo_reg   <= CURVE_TAB[idx];
                    hi_reg   <= CURVE_TAB[idx + IDX_BITS'(1)];
                    frac_reg <= FRAC_BITS'(u << CURVE_BITS);
                end
            end
            BK_INTERP:
            begin
                gain_reg <= (work_ph_reg == PH_RELEASE) ? (GAIN_ONE - interp_g) : interp_g;
            end
            BK_MUL:
            begin
                res_level_reg <= mul_level;
            end
            default:
            begin
            end
        endcase
        if (commit)
        begin
            out_reg.level   <= res_level_reg;
            out_reg.playing <= res_alive_reg;
            out_reg.stage   <= res_ph_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== src/adsr_envelope_generator.sv =====
// ADSR envelope generator: one envelope sample per sample tick.
// A tick transaction on the item channel (item_valid, item_stall, item)
// carries the note trigger and a restart flag; for each one the block
// returns exactly one result transaction (result_valid, result_stall,
// result) with the envelope level, a playing flag and the phase reached.
// Envelope lengths and levels are set through the APB-style port, by the
// user only while no tick is in flight; the block does not enforce it.
// Ticks enter a two-entry queue and are taken one at a time by the
// sequencer, which takes no new tick until the last result is committed.
// A tick in sustain or ended goes from the queue straight to the result
// register; attack runs the bit-serial divider that forms the segment
// fraction, then the level multiply; decay and release run the divider,
// the curve table read, interpolation and level multiply. The divider is
// skipped when the position has already reached the segment length.
// A finished result waits in the output register while the queue keeps
// taking ticks; when the receiver holds result_stall, the sequencer waits
// with its next result and the queue fills and then stalls the sender.
// Reset restores register defaults and puts the envelope in attack at
// position zero; no clearing pass is needed.
module adsr_envelope_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [adsr_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [adsr_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [adsr_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  adsr_pkg::in_item_t                   item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output adsr_pkg::out_item_t                  result
);
    import adsr_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_write;
    logic [2:0] reg_index;

    logic       q_valid;
    in_item_t   q_item;
    logic       q_pop;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register file. Writes to unused addresses are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_len    <= '0;
            cfg_reg.decay_len     <= '0;
            cfg_reg.sustain_level <= SUSTAIN_RESET;
            cfg_reg.release_len   <= '0;
            cfg_reg.peak_level    <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_ATTACK_LEN:    cfg_reg.attack_len    <= pwdata[TIME_BITS-1:0];
                REG_DECAY_LEN:     cfg_reg.decay_len     <= pwdata[TIME_BITS-1:0];
                REG_SUSTAIN_LEVEL: cfg_reg.sustain_level <= pwdata[LEVEL_BITS-1:0];
                REG_RELEASE_LEN:   cfg_reg.release_len   <= pwdata[TIME_BITS-1:0];
                REG_PEAK_LEVEL:    cfg_reg.peak_level    <= pwdata[LEVEL_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read data is combinational; the port never inserts wait states.
    always_comb
    begin
        case (reg_index)
            REG_ATTACK_LEN:    prdata = CFG_DATA_BITS'(cfg_reg.attack_len);
            REG_DECAY_LEN:     prdata = CFG_DATA_BITS'(cfg_reg.decay_len);
            REG_SUSTAIN_LEVEL: prdata = CFG_DATA_BITS'(cfg_reg.sustain_level);
            REG_RELEASE_LEN:   prdata = CFG_DATA_BITS'(cfg_reg.release_len);
            REG_PEAK_LEVEL:    prdata = CFG_DATA_BITS'(cfg_reg.peak_level);
            default:           prdata = '0;
        endcase
    end

    // Front end: accepts tick transactions into the queue.
    adsr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Back end: phase sequencer, divider, curve and level arithmetic.
    adsr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the ADSR envelope generator.
// Every accepted tick transaction is run through a predictor that keeps its
// own copy of the envelope phase, segment position and register settings.
// The predicted result is pushed on a queue, and a checker process compares
// each accepted result transaction with the oldest prediction, field by field.
// Test tasks are run in turn from one initial block. Registers are only
// written once every predicted result has been taken and the block is idle.
module tb;

    import adsr_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     item_valid;
    logic                     item_stall;
    in_item_t                 item;
    logic                     result_valid;
    logic                     result_stall;
    out_item_t                result;

    // Predictor state and its copy of the registers.
    logic [TIME_BITS-1:0]  exp_attack_len;
    logic [TIME_BITS-1:0]  exp_decay_len;
    logic [LEVEL_BITS-1:0] exp_sustain;
    logic [TIME_BITS-1:0]  exp_release_len;
    logic [LEVEL_BITS-1:0] exp_peak;
    logic [TIME_BITS-1:0]  env_position;
    phase_t                env_phase;

    // Our own copy of the log curve, built from the same Q30 series.
    logic [16:0] log_curve [0:CURVE_ENTRIES];

    out_item_t pending_envelopes [$];
    int        error_count;
    int        hold_off_cycles;
    bit        stall_pattern_on;

    adsr_envelope_generator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    initial
    begin
        #200000000;
        $display("adsr_envelope_generator regression: fail");
        $finish;
    end

    function automatic void fill_log_curve();
        longint unsigned y;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned v;
        longint unsigned last;
        last = 0;
        for (int k = 0; k <= CURVE_ENTRIES; k++)
        begin
            y    = 64'd1073741824 + (64'd1844991065 * longint'(k)) / CURVE_ENTRIES;
            z    = ((y - 64'd1073741824) << 30) / (y + 64'd1073741824);
            z2   = (z * z) >> 30;
            term = z;
            acc  = 0;
            for (int n = 0; n < 24; n++)
            begin
                acc  = acc + term / longint'(2 * n + 1);
                term = (term * z2) >> 30;
            end
            v = (2 * acc + 64'd8192) >> 14;
            if (v > 64'd65536)
            begin
                v = 64'd65536;
            end
            if (v < last)
            begin
                v = last;
            end
            log_curve[k] = v[16:0];
            last = v;
        end
    endfunction

    function automatic longint unsigned log_gain(longint unsigned u);
        longint unsigned p;
        longint unsigned idx;
        if (u > 65536)
        begin
            u = 65536;
        end
        p   = u * CURVE_ENTRIES;
        idx = p >> 16;
        if (idx >= CURVE_ENTRIES)
        begin
            return log_curve[CURVE_ENTRIES];
        end
        return log_curve[idx] + (((log_curve[idx + 1] - log_curve[idx]) * (p & 16'hFFFF)) >> 16);
    endfunction

    function automatic longint unsigned segment_fraction(longint unsigned pos,
                                                         longint unsigned len);
        longint unsigned f;
        if (len == 0 || pos >= len)
        begin
            return 65535;
        end
        f = (pos << 16) / len;
        return (f > 65535) ? 65535 : f;
    endfunction

    // Advances the envelope by one tick and returns the expected sample.
    function automatic out_item_t next_envelope(in_item_t tick);
        out_item_t       o;
        bit              held;
        longint unsigned pk;
        longint unsigned s;
        longint unsigned lvl;
        longint unsigned x;
        longint unsigned g;
        longint unsigned pos;
        held = (tick.trigger != 2'd0);
        pk   = (exp_peak != 0) ? exp_peak : 65535;
        s    = exp_sustain;
        lvl  = 0;
        o.playing = 1'b0;
        pos  = env_position;
        if (tick.restart)
        begin
            pos = 0;
            env_phase = (exp_attack_len == 0) ? PH_DECAY : PH_ATTACK;
        end
        if (env_phase == PH_ATTACK && exp_attack_len == 0)
        begin
            env_phase = PH_DECAY;
            pos = 0;
        end
        if (env_phase == PH_DECAY && exp_decay_len == 0)
        begin
            env_phase = PH_SUSTAIN;
            pos = 0;
        end
        case (env_phase)
            PH_ATTACK:
            begin
                x   = segment_fraction(pos, exp_attack_len);
                lvl = (x * pk) >> 16;
                o.playing = 1'b1;
                pos = (pos + 1) & 24'hFFFFFF;
                if (pos >= exp_attack_len)
                begin
                    env_phase = PH_DECAY;
                    pos = 0;
                end
            end
            PH_DECAY:
            begin
                x = segment_fraction(pos, exp_decay_len);
                g = log_gain(65536 - x);
                if (pk >= s)
                begin
                    lvl = s + ((g * (pk - s)) >> 16);
                end
                else
                begin
                    lvl = s - ((g * (s - pk)) >> 16);
                end
                o.playing = 1'b1;
                pos = (pos + 1) & 24'hFFFFFF;
                if (pos >= exp_decay_len)
                begin
                    env_phase = PH_SUSTAIN;
                    pos = 0;
                end
            end
            PH_SUSTAIN:
            begin
                if (s == 0)
                begin
                    env_phase = PH_ENDED;
                end
                else
                begin
                    lvl = s;
                    o.playing = 1'b1;
                    if (!held)
                    begin
                        env_phase = PH_RELEASE;
                    end
                end
            end
            PH_RELEASE:
            begin
                if (exp_release_len == 0 || pos >= exp_release_len)
                begin
                    env_phase = PH_ENDED;
                end
                else
                begin
                    x   = segment_fraction(pos, exp_release_len);
                    g   = 65536 - log_gain(x);
                    lvl = (g * s) >> 16;
                    o.playing = 1'b1;
                    pos = (pos + 1) & 24'hFFFFFF;
                end
                if (held)
                begin
                    pos = 0;
                    env_phase = PH_ATTACK;
                end
            end
            default:
            begin
                env_phase = PH_ENDED;
                if (held)
                begin
                    pos = 0;
                    env_phase = PH_ATTACK;
                end
            end
        endcase
        env_position = pos[TIME_BITS-1:0];
        o.level = lvl[LEVEL_BITS-1:0];
        o.stage = env_phase;
        return o;
    endfunction

    // The receiver stalls on its own pattern, or holds off for a long
    // stretch when a test asks for it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            result_stall    <= 1'b1;
        end
        else if (stall_pattern_on)
        begin
            result_stall <= ($urandom_range(0, 3) == 0);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Every accepted result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_envelopes.size() == 0)
            begin
                $error("result transaction with no prediction waiting");
                error_count++;
            end
            else
            begin
                out_item_t want;
                want = pending_envelopes.pop_front();
                if (result.level !== want.level)
                begin
                    $error("level: expected %0d, got %0d", want.level, result.level);
                    error_count++;
                end
                if (result.playing !== want.playing)
                begin
                    $error("playing: expected %0d, got %0d", want.playing, result.playing);
                    error_count++;
                end
                if (result.stage !== want.stage)
                begin
                    $error("stage: expected %0d, got %0d", want.stage, result.stage);
                    error_count++;
                end
            end
        end
    end

    // Sends one tick; the prediction is made when the transaction is taken.
    // Valid stays high straight into the next tick of a burst.
    task automatic send_tick(logic [1:0] trig, logic rst_flag);
        in_item_t t;
        t.trigger = trig;
        t.restart = rst_flag;
        item_valid <= 1'b1;
        item       <= t;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        pending_envelopes.push_back(next_envelope(t));
    endtask

    task automatic idle_sender(int cycles);
        item_valid <= 1'b0;
        repeat (cycles)
        begin
            @(posedge clk);
        end
    endtask

    // Random bursts of ticks with random gaps, weighted toward held notes.
    task automatic send_random_ticks(int count);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    idle_sender($urandom_range(1, 25));
                end
                burst = $urandom_range(1, 40);
            end
            burst--;
            send_tick(($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) :
                      (($urandom_range(0, 1) == 0) ? 2'd0 : 2'd1),
                      ($urandom_range(0, 30) == 0));
        end
        item_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_envelopes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_ATTACK_LEN:    exp_attack_len  = value[TIME_BITS-1:0];
            REG_DECAY_LEN:     exp_decay_len   = value[TIME_BITS-1:0];
            REG_SUSTAIN_LEVEL: exp_sustain     = value[LEVEL_BITS-1:0];
            REG_RELEASE_LEN:   exp_release_len = value[TIME_BITS-1:0];
            REG_PEAK_LEVEL:    exp_peak        = value[LEVEL_BITS-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_envelope(int a, int d, int s, int r, int p);
        wait_idle();
        write_reg(REG_ATTACK_LEN, a);
        write_reg(REG_DECAY_LEN, d);
        write_reg(REG_SUSTAIN_LEVEL, s);
        write_reg(REG_RELEASE_LEN, r);
        write_reg(REG_PEAK_LEVEL, p);
    endtask

    // Reset settings: all lengths zero, so a tick lands in sustain, walks
    // through the zero release into ended, or retriggers from ended.
    task automatic test_reset_defaults();
        send_tick(2'd1, 1'b0);
        send_tick(2'd0, 1'b0);
        send_tick(2'd0, 1'b0);
        send_tick(2'd2, 1'b0);
        send_tick(2'd3, 1'b1);
    endtask

    // One full note through each phase, then the special cases: sustain
    // above peak, zero sustain, retrigger during release and after the end.
    task automatic test_directed_phases();
        set_envelope(4, 5, 20000, 6, 0);
        send_tick(2'd1, 1'b1);
        repeat (10) send_tick(2'd1, 1'b0);
        repeat (3) send_tick(2'd0, 1'b0);
        send_tick(2'd2, 1'b0);
        repeat (8) send_tick(2'd0, 1'b0);
        set_envelope(3, 3, 60000, 2, 1000);
        send_tick(2'd3, 1'b1);
        repeat (7) send_tick(2'd1, 1'b0);
        set_envelope(0, 2, 0, 0, 65535);
        send_tick(2'd1, 1'b1);
        repeat (4) send_tick(2'd1, 1'b0);
        // A length shortened mid segment clamps the fraction and ends it.
        set_envelope(100, 0, 65535, 16777215, 0);
        send_tick(2'd1, 1'b1);
        repeat (5) send_tick(2'd1, 1'b0);
        set_envelope(2, 0, 65535, 16777215, 0);
        repeat (3) send_tick(2'd1, 1'b0);
        send_tick(2'd0, 1'b0);
    endtask

    // Random notes over several settings, the extremes among them.
    task automatic test_random_settings();
        set_envelope(16777215, 16777215, 65535, 16777215, 65535);
        send_random_ticks(60);
        set_envelope(1, 1, 1, 1, 1);
        send_random_ticks(80);
        for (int k = 0; k < 18; k++)
        begin
            set_envelope($urandom_range(0, 20), $urandom_range(0, 20),
                         ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535),
                         $urandom_range(0, 20),
                         ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535));
            send_random_ticks(55);
        end
    endtask

    // The receiver holds off long enough for the queue to fill and stall
    // the sender, which keeps offering ticks.
    task automatic test_back_pressure();
        set_envelope(8, 8, 30000, 8, 50000);
        stall_pattern_on = 1'b0;
        hold_off_cycles  = 300;
        repeat (30) send_tick(2'd1, 1'b0);
        item_valid <= 1'b0;
        stall_pattern_on = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        item = '0;
        error_count = 0;
        hold_off_cycles = 0;
        stall_pattern_on = 1'b1;
        fill_log_curve();
        exp_attack_len = '0;
        exp_decay_len = '0;
        exp_sustain = 16'hFFFF;
        exp_release_len = '0;
        exp_peak = '0;
        env_position = '0;
        env_phase = PH_ATTACK;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_phases();
        test_back_pressure();
        test_random_settings();
        wait_idle();
        if (error_count == 0)
        begin
            $display("adsr_envelope_generator regression: pass");
        end
        else
        begin
            $display("adsr_envelope_generator regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/adsr_pkg.sv
src/adsr_front.sv
src/adsr_back.sv
src/adsr_envelope_generator.sv
verif/tb.sv
